>>> rtl/core/lru_digest_tag_cache_assert.svh
// Assertion macros for the tag cache.
`ifndef LRU_DIGEST_TAG_CACHE_ASSERT_SVH
`define LRU_DIGEST_TAG_CACHE_ASSERT_SVH

// Same-cycle implication.
`define LRUDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru tag cache assertion failed");

// Next-cycle implication.
`define LRUDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru tag cache assertion failed");

`endif

>>> rtl/core/lrudc_pkg.sv
// ---------------------------------------------------------------------------
// lrudc_pkg
// Shared types and constants of the digest tag cache.
// ---------------------------------------------------------------------------
package lrudc_pkg;

  localparam int KeyBits   = 256;
  localparam int InTimeW   = 48;
  localparam int LimitW    = 7;
  localparam int SlotW     = 6;
  localparam int CountW    = 7;
  localparam int InDataW   = 304;
  localparam int OutDataW  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_WAIT,
    ST_WRITE,
    ST_OUT
  } state_e;

  // Per-cell update request.
  typedef struct packed {
    logic write;
    logic touch;
    logic clear;
  } cell_cmd_t;

endpackage

>>> rtl/core/lru_digest_tag_cache.sv
// ---------------------------------------------------------------------------
// lru_digest_tag_cache
// Fully associative tag cache on a 256-bit digest with oldest-stamp eviction.
// ---------------------------------------------------------------------------
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata keys+now, tuser command
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata hit/slot/evicted/count
// cfg       in   cfg_valid/cfg_ready           cfg_data entry_limit
//
// A hit or a lookup miss goes from the compare state straight to the result;
// an insert into a free slot passes through the write state first. An insert
// that evicts first waits for the oldest-entry chain in the cells to settle.
// One request is in flight at a time; the next is taken once the result
// is taken. Reset clears valid bits, count and limit (to 64) at once.
// ---------------------------------------------------------------------------
module lru_digest_tag_cache #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [63:0] key_word0, [127:64] key_word1, [191:128] key_word2,
  // [255:192] key_word3, [303:256] now_ms
  input  logic [lrudc_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] command
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] hit, [6:1] slot, [7] evicted, [14:8] entries_in_use, [15] zero
  output logic [lrudc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrudc_pkg::LimitW-1:0]    cfg_data
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WAIT_W = $clog2(CAPACITY + 2);
  localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(CAPACITY + 1);

  lrudc_pkg::state_e state_q, state_d;

  logic [lrudc_pkg::LimitW-1:0]  limit_q;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [WAIT_W-1:0]             wait_q, wait_d;
  logic                          cmd_q;
  logic [lrudc_pkg::KeyBits-1:0] key_q;
  logic [TIME_BITS-1:0]          now_q;
  logic                          hit_q, hit_d;
  logic [IDX_W-1:0]              slot_q, slot_d;
  logic                          ev_q, ev_d;

  lrudc_pkg::cell_cmd_t cmd_vec [CAPACITY];
  logic [CAPACITY-1:0]  valid_vec;
  logic [CAPACITY-1:0]  match_vec;
  logic                 lk_vld   [CAPACITY+1];
  logic [TIME_BITS-1:0] lk_stamp [CAPACITY+1];
  logic [IDX_W-1:0]     lk_idx   [CAPACITY+1];

  logic [IDX_W-1:0]     match_idx;
  logic [IDX_W-1:0]     free_idx;
  logic [CAPACITY-1:0]  free_vec;
  logic [31:0]          lim32, eff32, cnt32;
  logic                 need_evict;
  logic [63:0]          now64;
  logic [31:0]          slot32, cnt_out32;

  assign now64 = {16'b0, s_axis_tdata[303:256]};

  assign lk_vld[0]   = 1'b0;
  assign lk_stamp[0] = '0;
  assign lk_idx[0]   = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lrudc_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .CELL_ID   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_vec[g]),
      .key_i        (key_q),
      .now_i        (now_q),
      .link_vld_i   (lk_vld[g]),
      .link_stamp_i (lk_stamp[g]),
      .link_idx_i   (lk_idx[g]),
      .valid_o      (valid_vec[g]),
      .match_o      (match_vec[g]),
      .link_vld_o   (lk_vld[g+1]),
      .link_stamp_o (lk_stamp[g+1]),
      .link_idx_o   (lk_idx[g+1])
    );
  end

  // Keys are unique, so the match vector is one-hot or empty.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    free_vec = ~valid_vec;
    if (ev_q) begin
      free_vec[lk_idx[CAPACITY]] = 1'b1;
    end
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign lim32 = {25'b0, limit_q};
  assign cnt32 = 32'(cnt_q);
  assign eff32 = (lim32 == 32'd0) ? 32'd1 :
                 (lim32 > 32'(CAPACITY)) ? 32'(CAPACITY) : lim32;
  assign need_evict = (cnt32 >= eff32) || (&valid_vec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrudc_pkg::ST_IDLE;
      limit_q <= lrudc_pkg::LimitW'(64);
      cnt_q   <= '0;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
      if (cfg_valid) begin
        limit_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      key_q <= s_axis_tdata[255:0];
      now_q <= now64[TIME_BITS-1:0];
    end
    hit_q  <= hit_d;
    slot_q <= slot_d;
    ev_q   <= ev_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wait_d  = wait_q;
    hit_d   = hit_q;
    slot_d  = slot_q;
    ev_d    = ev_q;
    for (int i = 0; i < CAPACITY; i++) begin
      cmd_vec[i] = '0;
    end
    case (state_q)
      lrudc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = lrudc_pkg::ST_CMP;
        end
      end
      lrudc_pkg::ST_CMP: begin
        hit_d  = 1'b0;
        slot_d = '0;
        ev_d   = 1'b0;
        if (|match_vec) begin
          hit_d  = 1'b1;
          slot_d = match_idx;
          cmd_vec[match_idx].touch = 1'b1;
          state_d = lrudc_pkg::ST_OUT;
        end else if (!cmd_q) begin
          state_d = lrudc_pkg::ST_OUT;
        end else if (need_evict) begin
          wait_d  = WAIT_LOAD;
          state_d = lrudc_pkg::ST_WAIT;
        end else begin
          state_d = lrudc_pkg::ST_WRITE;
        end
      end
      lrudc_pkg::ST_WAIT: begin
        // hold until the chain tail carries the oldest slot
        if (wait_q == '0) begin
          ev_d    = lk_vld[CAPACITY];
          state_d = lrudc_pkg::ST_WRITE;
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      lrudc_pkg::ST_WRITE: begin
        if (ev_q) begin
          cmd_vec[lk_idx[CAPACITY]].clear = 1'b1;
        end
        cmd_vec[free_idx].write = 1'b1;
        slot_d  = free_idx;
        cnt_d   = cnt_q - CNT_W'(ev_q) + 1'b1;
        state_d = lrudc_pkg::ST_OUT;
      end
      lrudc_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = lrudc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrudc_pkg::ST_IDLE;
      end
    endcase
  end

  assign slot32    = 32'(slot_q);
  assign cnt_out32 = 32'(cnt_q);

  assign s_axis_tready = (state_q == lrudc_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == lrudc_pkg::ST_OUT);
  assign m_axis_tdata  = {1'b0, cnt_out32[lrudc_pkg::CountW-1:0], ev_q,
                          slot32[lrudc_pkg::SlotW-1:0], hit_q};
  assign cfg_ready     = 1'b1;

`include "lru_digest_tag_cache_assert.svh"

  `LRUDC_ASSERT_IMP(a_match_unique, 1'b1, $onehot0(match_vec))
  `LRUDC_ASSERT_IMP(a_count_bound, 1'b1, cnt32 <= 32'(CAPACITY))
  `LRUDC_ASSERT_IMP(a_one_side, m_axis_tvalid, !s_axis_tready)
  `LRUDC_ASSERT_NXT(a_accept_cmp, s_axis_tvalid && s_axis_tready,
                    state_q == lrudc_pkg::ST_CMP)

endmodule

>>> rtl/core/lrudc_cell.sv
// ---------------------------------------------------------------------------
// lrudc_cell
// One cache slot: key, stamp and valid, key compare, and one stage of the
// oldest-entry chain that runs from slot 0 upward.
// ---------------------------------------------------------------------------
module lrudc_cell #(
  parameter int TIME_BITS = 48,
  parameter int IDX_W     = 6,
  parameter int CELL_ID   = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lrudc_pkg::cell_cmd_t      cmd_i,
  input  logic [lrudc_pkg::KeyBits-1:0] key_i,
  input  logic [TIME_BITS-1:0]      now_i,
  input  logic                      link_vld_i,
  input  logic [TIME_BITS-1:0]      link_stamp_i,
  input  logic [IDX_W-1:0]          link_idx_i,
  output logic                      valid_o,
  output logic                      match_o,
  output logic                      link_vld_o,
  output logic [TIME_BITS-1:0]      link_stamp_o,
  output logic [IDX_W-1:0]          link_idx_o
);

  logic                          valid_q;
  logic [lrudc_pkg::KeyBits-1:0] key_q;
  logic [TIME_BITS-1:0]          stamp_q;
  logic                          link_vld_q;
  logic [TIME_BITS-1:0]          link_stamp_q;
  logic [IDX_W-1:0]              link_idx_q;
  logic                          take_self;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      valid_q <= 1'b1;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      key_q <= key_i;
    end
    if (cmd_i.write || cmd_i.touch) begin
      stamp_q <= now_i;
    end
  end

  // Strictly older wins, so ties stay with the lower slot.
  assign take_self = valid_q && (!link_vld_i || (stamp_q < link_stamp_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= 1'b0;
    end else begin
      link_vld_q <= link_vld_i || valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    link_stamp_q <= take_self ? stamp_q : link_stamp_i;
    link_idx_q   <= take_self ? IDX_W'(CELL_ID) : link_idx_i;
  end

  assign valid_o      = valid_q;
  assign match_o      = valid_q && (key_q == key_i);
  assign link_vld_o   = link_vld_q;
  assign link_stamp_o = link_stamp_q;
  assign link_idx_o   = link_idx_q;

endmodule

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Exercises the digest tag cache: lookups and inserts over a small key pool,
// LRU eviction under several entry limits, each response checked in order.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;
  localparam int RandomRequests = 1450;
  localparam int CycleLimit = 400000;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdInsert = 1'b1;

  typedef struct packed {
    logic       hit;
    logic [5:0] slot;
    logic       evicted;
    logic [6:0] in_use;
  } resp_t;

  typedef struct {
    logic          cmd;
    logic [255:0]  key;
    logic [47:0]   now;
    logic          known;
    resp_t         resp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [lrudc_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [lrudc_pkg::OutDataW-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrudc_pkg::LimitW-1:0] cfg_data = '0;

  lru_digest_tag_cache uut (.*);

  always #5 clk_i = ~clk_i;

  // Cache shadow.
  logic [6:0]   limit_reg;
  logic         line_valid [Slots];
  logic [255:0] line_key [Slots];
  logic [47:0]  line_stamp [Slots];
  int           live;

  resp_t pending_resps[$];
  logic  pending_known[$];
  resp_t typed_resps[$];
  int errors = 0;
  int cycles = 0;
  int n_resps = 0;
  int n_evicts = 0;
  logic [255:0] key_pool [24];

  function automatic resp_t cache_access(logic cmd, logic [255:0] key, logic [47:0] now);
    resp_t r;
    int s, lim, best, fr;
    r = '0;
    s = -1;
    for (int i = 0; i < Slots; i++)
      if (s < 0 && line_valid[i] && line_key[i] == key) s = i;
    if (s >= 0) begin
      line_stamp[s] = now;
      r.hit = 1'b1;
      r.slot = s[5:0];
    end else if (cmd == CmdInsert) begin
      lim = (limit_reg == 0) ? 1 : (limit_reg > Slots) ? Slots : int'(limit_reg);
      fr = -1;
      for (int i = Slots - 1; i >= 0; i--) if (!line_valid[i]) fr = i;
      if (live >= lim || fr < 0) begin
        best = -1;
        for (int i = 0; i < Slots; i++)
          if (line_valid[i] && (best < 0 || line_stamp[i] < line_stamp[best])) best = i;
        if (best >= 0) begin
          line_valid[best] = 1'b0;
          live--;
          r.evicted = 1'b1;
        end
      end
      fr = -1;
      for (int i = Slots - 1; i >= 0; i--) if (!line_valid[i]) fr = i;
      if (fr >= 0) begin
        line_valid[fr] = 1'b1;
        line_key[fr] = key;
        line_stamp[fr] = now;
        live++;
        r.slot = fr[5:0];
      end
    end
    r.in_use = live[6:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("FAIL");
      $finish;
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    resp_t got, want, typed_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got.hit     = m_axis_tdata[0];
      got.slot    = m_axis_tdata[6:1];
      got.evicted = m_axis_tdata[7];
      got.in_use  = m_axis_tdata[14:8];
      if (pending_resps.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
      end else begin
        want = pending_resps.pop_front();
        if (pending_known.pop_front()) begin
          typed_r = typed_resps.pop_front();
          if (typed_r != want) begin
            $display("%0t: table row disagrees with shadow, table %h shadow %h",
                     $time, typed_r, want);
            errors++;
          end
        end
        if (got.hit !== want.hit || got.slot !== want.slot ||
            got.evicted !== want.evicted || got.in_use !== want.in_use ||
            m_axis_tdata[15] !== 1'b0) begin
          $display("%0t: response mismatch expected hit %b slot %0d ev %b use %0d, got %h",
                   $time, want.hit, want.slot, want.evicted, want.in_use, m_axis_tdata);
          errors++;
        end
        n_resps++;
        if (want.evicted) n_evicts++;
      end
    end
  end

  // Response stall.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Leaves tvalid high after the accept; the next request or the caller drops it.
  task automatic send_request(logic cmd, logic [255:0] key, logic [47:0] now,
                              logic known = 1'b0, resp_t typed = '0);
    resp_t r;
    int w;
    w = $urandom_range(0, 6);
    if (w != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    s_axis_tdata <= {now, key[63:0], key[127:64], key[191:128], key[255:192]};
    s_axis_tuser <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = cache_access(cmd, key, now);
    pending_resps.push_back(r);
    pending_known.push_back(known);
    if (known) typed_resps.push_back(typed);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set_limit(logic [6:0] lim);
    s_axis_tvalid <= 1'b0;
    while (pending_resps.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_data <= lim;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    limit_reg = lim;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    logic [255:0] k;
    logic [47:0] clock_ms;
    logic [6:0] limits[6];
    limits = '{7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd64};
    limit_reg = 7'd64;
    live = 0;
    clock_ms = 48'd1000;
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = rand_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; typed responses only where obvious.
    rows.push_back('{CmdLookup, '0, 48'd0, 1'b1, resp_t'{1'b0, 6'd0, 1'b0, 7'd0}});
    rows.push_back('{CmdInsert, '0, 48'd0, 1'b1, resp_t'{1'b0, 6'd0, 1'b0, 7'd1}});
    rows.push_back('{CmdInsert, '1, '1, 1'b1, resp_t'{1'b0, 6'd1, 1'b0, 7'd2}});
    rows.push_back('{CmdLookup, '1, 48'd5, 1'b1, resp_t'{1'b1, 6'd1, 1'b0, 7'd2}});
    rows.push_back('{CmdInsert, '0, 48'd7, 1'b1, resp_t'{1'b1, 6'd0, 1'b0, 7'd2}});
    rows.push_back('{CmdLookup, {64'h1, 192'h0}, 48'd9, 1'b1, resp_t'{1'b0, 6'd0, 1'b0, 7'd2}});
    rows.push_back('{CmdInsert, {192'h0, 64'h1}, 48'd3, 1'b0, resp_t'('0)});
    rows.push_back('{CmdInsert, {128'h0, {2{64'h5555_aaaa_5555_aaaa}}}, 48'd3, 1'b0, resp_t'('0)});
    rows.push_back('{CmdInsert, {{2{64'haaaa_5555_aaaa_5555}}, 128'h0}, 48'd2, 1'b0, resp_t'('0)});
    foreach (rows[i]) begin
      rw = rows[i];
      send_request(rw.cmd, rw.key, rw.now, rw.known, rw.resp);
    end

    // Ties and backward time under a limit of three.
    drain_and_set_limit(7'd3);
    send_request(CmdInsert, key_pool[2], 48'd100);
    send_request(CmdInsert, key_pool[3], 48'd100);
    send_request(CmdInsert, key_pool[4], 48'd100);
    send_request(CmdInsert, key_pool[5], 48'd50);
    send_request(CmdLookup, key_pool[5], 48'd1);
    send_request(CmdInsert, key_pool[6], 48'd1);

    // Random phases across limits, extremes included.
    for (int p = 0; p < 6; p++) begin
      drain_and_set_limit(limits[p]);
      for (int i = 0; i < RandomRequests / 6; i++) begin
        k = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, 23)];
        clock_ms = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom})
                 : clock_ms + $urandom_range(0, 3);
        send_request(logic'($urandom_range(0, 1)), k, clock_ms);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_resps.size() != 0) @(negedge clk_i);
    repeat (Slots + 10) @(negedge clk_i);
    $display("checked %0d responses, %0d with eviction, limits 0..127 exercised",
             n_resps, n_evicts);
    if (errors == 0 && pending_resps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
